@@ design/vsnmv_pkg.sv @@
// Shared types and constants for the six-neighbour majority vote block.
// No dependencies; compiled first.
package vsnmv_pkg;

    localparam int unsigned FIELD_BITS         = 32;  // width of every label field on the ports
    localparam int unsigned LABEL_BITS_DEFAULT = 32;
    localparam int unsigned NUM_DIRS           = 6;
    localparam int unsigned DIR_BITS           = 3;
    localparam int unsigned CNT_BITS           = $clog2(NUM_DIRS + 1);

    // Scan order of the neighbours, also the bit order of the presence mask
    typedef enum logic [DIR_BITS-1:0] {
        DIR_MINUS_Z = 3'd0,
        DIR_MINUS_Y = 3'd1,
        DIR_MINUS_X = 3'd2,
        DIR_PLUS_X  = 3'd3,
        DIR_PLUS_Y  = 3'd4,
        DIR_PLUS_Z  = 3'd5
    } dir_t;

    typedef logic [CNT_BITS-1:0] cnt_t;

    typedef struct packed {
        logic                  is_bad;
        logic                  filled;
        dir_t                  source_direction;
        logic [FIELD_BITS-1:0] new_label;
    } vote_result_t;

endpackage

@@ design/vsnmv_if.sv @@
// Valid/ready channel interfaces for the voxel request and the vote result.
// Depends on vsnmv_pkg.
interface vsnmv_in_if
    import vsnmv_pkg::*;
    ();
    logic                  valid;
    logic                  ready;
    logic [FIELD_BITS-1:0] center_label;
    logic [FIELD_BITS-1:0] label_minus_z;
    logic [FIELD_BITS-1:0] label_minus_y;
    logic [FIELD_BITS-1:0] label_minus_x;
    logic [FIELD_BITS-1:0] label_plus_x;
    logic [FIELD_BITS-1:0] label_plus_y;
    logic [FIELD_BITS-1:0] label_plus_z;
    logic [NUM_DIRS-1:0]   neighbor_present;

    modport source (
        output valid, center_label, label_minus_z, label_minus_y, label_minus_x,
               label_plus_x, label_plus_y, label_plus_z, neighbor_present,
        input  ready
    );
    modport sink (
        input  valid, center_label, label_minus_z, label_minus_y, label_minus_x,
               label_plus_x, label_plus_y, label_plus_z, neighbor_present,
        output ready
    );
endinterface

interface vsnmv_out_if
    import vsnmv_pkg::*;
    ();
    logic                  valid;
    logic                  ready;
    logic                  is_bad;
    logic                  filled;
    logic [DIR_BITS-1:0]   source_direction;
    logic [FIELD_BITS-1:0] new_label;

    modport source (
        output valid, is_bad, filled, source_direction, new_label,
        input  ready
    );
    modport sink (
        input  valid, is_bad, filled, source_direction, new_label,
        output ready
    );
endinterface

@@ design/voxel_six_neighbor_majority_vote.sv @@
// Path: an accepted request is captured in the input stage, then voted into the result register, which offers it.
// Throughput: one request per cycle while result.ready does not stall; the input stage and the result register
// each hand on whenever the next stage is empty or being drained.
// Reset: rst_n asynchronous, active low; empties both stages, payload kept as is.
// Top level of the six-neighbour majority vote; depends on vsnmv_pkg, vsnmv_if
// and vsnmv_vote.
module voxel_six_neighbor_majority_vote
    import vsnmv_pkg::*;
#(
    parameter int unsigned LABEL_BITS = LABEL_BITS_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    vsnmv_in_if.sink     voxel,
    vsnmv_out_if.source  result
);

    // Input stage: labels trimmed to LABEL_BITS on capture
    logic                               in_valid_reg;
    logic                               in_valid_next;
    logic [LABEL_BITS-1:0]              center_reg;
    logic [LABEL_BITS-1:0]              center_next;
    logic [NUM_DIRS-1:0][LABEL_BITS-1:0] lab_reg;
    logic [NUM_DIRS-1:0][LABEL_BITS-1:0] lab_next;
    logic [NUM_DIRS-1:0]                present_reg;
    logic [NUM_DIRS-1:0]                present_next;

    // Result stage
    logic                               out_valid_reg;
    logic                               out_valid_next;
    vote_result_t                       out_reg;
    vote_result_t                       out_next;

    logic                               out_free;
    logic                               in_take;
    logic                               advance;
    vote_result_t                       vote;

    // Result register can load when empty or when its request is being taken
    assign out_free = !out_valid_reg || result.ready;
    assign advance  = in_valid_reg && out_free;

    // Input stage frees up in the same cycle it hands on, so requests stream
    assign voxel.ready = !in_valid_reg || out_free;
    assign in_take     = voxel.valid && voxel.ready;

    always_comb
    begin
        center_next              = voxel.center_label[LABEL_BITS-1:0];
        lab_next[DIR_MINUS_Z]    = voxel.label_minus_z[LABEL_BITS-1:0];
        lab_next[DIR_MINUS_Y]    = voxel.label_minus_y[LABEL_BITS-1:0];
        lab_next[DIR_MINUS_X]    = voxel.label_minus_x[LABEL_BITS-1:0];
        lab_next[DIR_PLUS_X]     = voxel.label_plus_x[LABEL_BITS-1:0];
        lab_next[DIR_PLUS_Y]     = voxel.label_plus_y[LABEL_BITS-1:0];
        lab_next[DIR_PLUS_Z]     = voxel.label_plus_z[LABEL_BITS-1:0];
        present_next             = voxel.neighbor_present;
        in_valid_next            = in_take || (in_valid_reg && !out_free);
        out_valid_next           = out_free ? in_valid_reg : 1'b1;
        out_next                 = vote;
    end

    // All the voting work sits between the two registers
    vsnmv_vote #(
        .LABEL_BITS (LABEL_BITS)
    ) u_vote (
        .center_label (center_reg),
        .labels       (lab_reg),
        .present      (present_reg),
        .vote         (vote)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload: loaded only on a handover, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            center_reg  <= center_next;
            lab_reg     <= lab_next;
            present_reg <= present_next;
        end
        if (advance)
        begin
            out_reg <= out_next;
        end
    end

    assign result.valid            = out_valid_reg;
    assign result.is_bad           = out_reg.is_bad;
    assign result.filled           = out_reg.filled;
    assign result.source_direction = out_reg.source_direction;
    assign result.new_label        = out_reg.new_label;

endmodule

@@ design/vsnmv_vote.sv @@
// Combinational vote: per-neighbour match counts and the running best pick.
// Depends on vsnmv_pkg.
module vsnmv_vote
    import vsnmv_pkg::*;
#(
    parameter int unsigned LABEL_BITS = LABEL_BITS_DEFAULT
) (
    input  logic [LABEL_BITS-1:0]               center_label,
    input  logic [NUM_DIRS-1:0][LABEL_BITS-1:0] labels,
    input  logic [NUM_DIRS-1:0]                 present,
    output vote_result_t                        vote
);

    logic [NUM_DIRS-1:0]       votes;
    cnt_t [NUM_DIRS-1:0]       cnt;
    logic                      bad;
    logic                      found;
    cnt_t                      most;
    dir_t                      best_dir;
    logic [LABEL_BITS-1:0]     best_lab;

    assign bad = center_label[LABEL_BITS-1];

    // Only present, strictly positive neighbours vote
    always_comb
    begin
        for (int d = 0; d < NUM_DIRS; d++)
        begin
            votes[d] = present[d] && !labels[d][LABEL_BITS-1] && (|labels[d]);
        end
    end

    // Count of earlier-or-equal voters sharing label d
    always_comb
    begin
        for (int d = 0; d < NUM_DIRS; d++)
        begin
            cnt[d] = '0;
            for (int e = 0; e < NUM_DIRS; e++)
            begin
                if (e <= d && votes[e] && labels[e] == labels[d])
                begin
                    cnt[d] = cnt[d] + cnt_t'(1);
                end
            end
        end
    end

    // Strictly-greater update: ties stay with the label that got there first
    always_comb
    begin
        most     = '0;
        best_dir = DIR_MINUS_Z;
        best_lab = '0;
        found    = 1'b0;
        for (int d = 0; d < NUM_DIRS; d++)
        begin
            if (votes[d] && cnt[d] > most)
            begin
                most     = cnt[d];
                best_dir = dir_t'(DIR_BITS'(d));
                best_lab = labels[d];
                found    = 1'b1;
            end
        end
    end

    always_comb
    begin
        vote.is_bad           = bad;
        vote.filled           = bad && found;
        vote.source_direction = (bad && found) ? best_dir : DIR_MINUS_Z;
        vote.new_label        = (bad && found) ? FIELD_BITS'(signed'(best_lab))
                                               : FIELD_BITS'(signed'(center_label));
    end

endmodule

@@ design/vsnmv_checker.sv @@
// Port-level checks for the six-neighbour majority vote, bound to the top level.
// Depends on vsnmv_pkg and voxel_six_neighbor_majority_vote.
module vsnmv_checker
    import vsnmv_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_ready,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic                  is_bad,
    input logic                  filled,
    input logic [DIR_BITS-1:0]   source_direction,
    input logic [FIELD_BITS-1:0] new_label
);

    // A stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result withdrawn while stalled");

    // Two-stage pipe: each request passes both stages to a result on offer
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |-> ##2 out_valid)
        else $error("no result two cycles after request");

    a_fill_bad: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && filled |-> is_bad && !new_label[FIELD_BITS-1] && new_label != '0)
        else $error("fill on good voxel or with non-positive label");

    a_nofill_dir: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !filled |-> source_direction == DIR_MINUS_Z)
        else $error("direction set without a fill");

    a_dir_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> source_direction <= DIR_PLUS_Z)
        else $error("direction out of range");

endmodule

bind voxel_six_neighbor_majority_vote vsnmv_checker u_vsnmv_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (voxel.valid),
    .in_ready         (voxel.ready),
    .out_valid        (result.valid),
    .out_ready        (result.ready),
    .is_bad           (result.is_bad),
    .filled           (result.filled),
    .source_direction (result.source_direction),
    .new_label        (result.new_label)
);
